@@ src/spm_pkg.sv @@
// package for the sorted prefix match table: types, sizes and codes
`default_nettype none
package spm_pkg;
  localparam int TableDepth = 256;
  localparam int KeyChars = 8;
  localparam int KeyW = 64;
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int IdxW = $clog2(TableDepth);

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LIST = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_ADD_OK = 3'd0,
    KIND_ADD_FULL = 3'd1,
    KIND_REMOVED = 3'd2,
    KIND_MATCH = 3'd3,
    KIND_SUMMARY = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [63:0] key;
    logic [3:0] prefix_len;
  } req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [63:0] match_key;
    logic [8:0] others_count;
    logic last;
  } resp_t;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } op_e;

  typedef struct packed {
    op_e op;
    logic [KeyW-1:0] key;
  } cell_ctl_t;

  // mask of key bits that belong to the key characters
  function automatic logic [KeyW-1:0] key_mask();
    logic [KeyW-1:0] m;
    m = '0;
    for (int i = 0; i < KeyW; i++) begin
      if (i < 8 * KeyChars) m[i] = 1'b1;
    end
    return m;
  endfunction

  // mask that keeps the first plen characters of a packed key
  function automatic logic [KeyW-1:0] prefix_mask(input logic [3:0] plen);
    logic [KeyW-1:0] m;
    logic [3:0] p;
    m = '0;
    p = (plen > 4'(KeyChars)) ? 4'(KeyChars) : plen;
    for (int i = 0; i < KeyW; i++) begin
      if (i < 8 * KeyChars && i >= 8 * (KeyChars - int'(p))) m[i] = 1'b1;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

@@ src/spm_cell.sv @@
// one cell of the sorted chain: holds one key slot and trades with its neighbours
`default_nettype none
module spm_cell (
  input  wire logic                     clk,
  input  wire spm_pkg::cell_ctl_t       ctl,
  input  wire logic                     occ,       // this slot holds a key
  input  wire logic [spm_pkg::KeyW-1:0] left_key,
  input  wire logic                     left_lt,   // left neighbour key below the op key
  input  wire logic [spm_pkg::KeyW-1:0] right_key, // last cell sees cell 0 here
  input  wire logic                     right_occ,
  input  wire logic                     first,
  output logic [spm_pkg::KeyW-1:0]      slot,
  output logic                          lt,        // stored key below op key
  output logic                          eq
);
  import spm_pkg::*;

  logic [KeyW-1:0] slot_next;

  assign lt = occ && (slot < ctl.key);
  assign eq = occ && (slot == ctl.key);

  // insert shifts right from the insertion point, delete shifts left from the hit,
  // rotate moves every key one cell towards cell 0 with wrap-around
  always_comb begin
    slot_next = slot;
    unique case (ctl.op)
      OP_INSERT: begin
        if (!lt) slot_next = (first || left_lt) ? ctl.key : left_key;
      end
      OP_DELETE: begin
        if (!lt && right_occ) slot_next = right_key;
      end
      OP_ROTATE: slot_next = right_key;
      default: slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end
endmodule
`default_nettype wire

@@ src/sorted_prefix_match_table.sv @@
// top level: sorted key chain of cells with a sequencer for add, remove and list
//
//  channel | signals                    | direction
//  req     | req_valid/req_ready/req    | in
//  resp    | resp_valid/resp_ready/resp | out
//  cfg     | cfg_we/cfg_wdata           | in
//
// add and remove: the chain shifts at the accepting edge and the result is valid the
// next cycle; a new request is taken in any cycle in which the result register drains
// list: the chain rotates once through all TableDepth cells, one cell per cycle in
// which the result register can take a result, then a summary result follows; no
// new request is taken until the list has finished
// reset empties the chain (count zero) and sets the list limit to 10
// results wait in one output register; the chain stops while it is full
`default_nettype none
module sorted_prefix_match_table (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire spm_pkg::req_t   req,
  output logic                 resp_valid,
  input  wire logic            resp_ready,
  output spm_pkg::resp_t       resp,
  input  wire logic            cfg_we,
  input  wire logic [5:0]      cfg_wdata
);
  import spm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LIST, S_SUM} state_e;

  state_e state;
  logic [CntW-1:0] count;
  logic [5:0] list_limit;
  logic [KeyW-1:0] op_key;
  logic [KeyW-1:0] pmask;
  logic [CntW-1:0] scan;
  logic [5:0] emitted;
  logic [8:0] others;
  cell_ctl_t ctl;

  logic [KeyW-1:0] slots [TableDepth];
  logic [TableDepth-1:0] lts, eqs, occs;

  // chain of cells
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    assign occs[g] = (CntW'(g) < count);
    spm_cell u_cell (
      .clk(clk), .ctl(ctl), .occ(occs[g]),
      .left_key(slots[(g + TableDepth - 1) % TableDepth]),
      .left_lt(g == 0 ? 1'b0 : lts[(g + TableDepth - 1) % TableDepth]),
      .right_key(slots[(g + 1) % TableDepth]),
      .right_occ(g == TableDepth - 1 ? 1'b0 : occs[(g + 1) % TableDepth]),
      .first(g == 0),
      .slot(slots[g]), .lt(lts[g]), .eq(eqs[g])
    );
  end

  logic hit;
  logic [KeyW-1:0] in_key;
  logic out_free;
  assign hit = |eqs;
  assign in_key = req.key & key_mask();
  assign out_free = !resp_valid || resp_ready;
  assign req_ready = (state == S_IDLE) && out_free;

  // cell operation chosen from the request at the head of the input, or rotate while listing
  always_comb begin
    ctl.op = OP_HOLD;
    ctl.key = in_key;
    if (state == S_IDLE && req_valid && out_free) begin
      if (req.req_type == REQ_ADD && !hit && count < CntW'(TableDepth)) ctl.op = OP_INSERT;
      if (req.req_type == REQ_REMOVE && hit) ctl.op = OP_DELETE;
    end else if (state == S_LIST && out_free) begin
      ctl.op = OP_ROTATE;
    end
  end

  // the chain is read at cell 0: each rotation brings the next key up in ascending order
  logic cur_match;
  assign cur_match = (scan < count) && ((slots[0] & pmask) == (op_key & pmask));

  // next result and whether it is loaded this cycle
  logic load;
  resp_t resp_next;
  always_comb begin
    load = 1'b0;
    resp_next = '0;
    if (state == S_IDLE && req_valid && out_free) begin
      resp_next.last = 1'b1;
      if (req.req_type == REQ_ADD) begin
        load = 1'b1;
        resp_next.kind = (!hit && count >= CntW'(TableDepth)) ? KIND_ADD_FULL : KIND_ADD_OK;
      end else if (req.req_type == REQ_REMOVE) begin
        load = 1'b1;
        resp_next.kind = KIND_REMOVED;
      end
    end else if (state == S_LIST && out_free) begin
      load = cur_match && (emitted < list_limit);
      resp_next.kind = KIND_MATCH;
      resp_next.match_key = slots[0];
    end else if (state == S_SUM && out_free) begin
      load = 1'b1;
      resp_next.kind = KIND_SUMMARY;
      resp_next.others_count = others;
      resp_next.last = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (load) begin
      resp_valid <= 1'b1;
      resp <= resp_next;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      list_limit <= 6'd10;
    end else begin
      if (cfg_we) list_limit <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (req_valid && out_free) begin
            if (ctl.op == OP_INSERT) count <= count + 1'b1;
            else if (ctl.op == OP_DELETE) count <= count - 1'b1;
            if (req.req_type == REQ_LIST) begin
              op_key <= in_key;
              pmask <= prefix_mask(req.prefix_len);
              scan <= '0;
              emitted <= '0;
              others <= '0;
              state <= S_LIST;
            end
          end
        end
        S_LIST: begin
          // after TableDepth rotation steps the chain is back in order
          if (out_free) begin
            if (cur_match) begin
              if (emitted < list_limit) emitted <= emitted + 1'b1;
              else if (others != 9'd511) others <= others + 1'b1;
            end
            scan <= scan + 1'b1;
            if (scan == CntW'(TableDepth - 1)) state <= S_SUM;
          end
        end
        S_SUM: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(TableDepth))
    else $error("entry count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_INSERT) |=> count == $past(count) + 1'b1)
    else $error("insert did not grow count");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> !req_ready)
    else $error("request taken during list");
  assert property (@(posedge clk) disable iff (rst)
    (resp_valid && !resp_ready) |=> (resp_valid && $stable(resp)))
    else $error("waiting result changed or dropped");
endmodule
`default_nettype wire

@@ dv/spm_checker.sv @@
// checker for the sorted prefix match table: request watcher, key-set predictor, response compare
module spm_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_ready,
  input  spm_pkg::req_t   req,
  input  logic            resp_valid,
  input  logic            resp_ready,
  input  spm_pkg::resp_t  resp,
  input  logic            cfg_we,
  input  logic [5:0]      cfg_wdata,
  output int              fails,
  output int              pending,
  output int              results_seen
);
  import spm_pkg::*;

  localparam logic [8:0] OthersMax = 9'd511;

  logic [63:0] stored_keys[$];
  resp_t       awaited_resp[$];
  logic [5:0]  list_limit;

  task automatic report_mismatch(input string msg);
    $display("checker: mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic resp_t make_resp(input kind_e k, input logic [63:0] mk,
                                      input logic [8:0] oc, input logic lst);
    resp_t r;
    r.kind = k;
    r.match_key = mk;
    r.others_count = oc;
    r.last = lst;
    return r;
  endfunction

  // append one predicted response at the back of the queue
  task automatic queue_resp(input resp_t r);
    awaited_resp = {awaited_resp, r};
  endtask

  // first position whose key is not below k
  function automatic int first_not_below(input logic [63:0] k);
    int i;
    i = 0;
    while (i < stored_keys.size() && stored_keys[i] < k) i++;
    return i;
  endfunction

  // work out the responses one request causes and update the key set
  task automatic predict_request(input req_t r);
    logic [63:0] k;
    logic [63:0] pmask;
    int          p;
    int          pos;
    int          emitted;
    logic [8:0]  others;
    k = r.key;
    case (r.req_type)
      REQ_ADD: begin
        pos = first_not_below(k);
        if (pos < stored_keys.size() && stored_keys[pos] == k) begin
          queue_resp(make_resp(KIND_ADD_OK, '0, '0, 1'b1));
        end else if (stored_keys.size() >= TableDepth) begin
          queue_resp(make_resp(KIND_ADD_FULL, '0, '0, 1'b1));
        end else begin
          stored_keys.insert(pos, k);
          queue_resp(make_resp(KIND_ADD_OK, '0, '0, 1'b1));
        end
      end
      REQ_REMOVE: begin
        pos = first_not_below(k);
        if (pos < stored_keys.size() && stored_keys[pos] == k) stored_keys.delete(pos);
        queue_resp(make_resp(KIND_REMOVED, '0, '0, 1'b1));
      end
      REQ_LIST: begin
        p = (r.prefix_len > 4'(KeyChars)) ? KeyChars : int'(r.prefix_len);
        pmask = (p == 0) ? '0 : ({64{1'b1}} << (8 * (KeyChars - p)));
        emitted = 0;
        others = '0;
        foreach (stored_keys[i]) begin
          if ((stored_keys[i] & pmask) == (k & pmask)) begin
            if (emitted < int'(list_limit)) begin
              queue_resp(make_resp(KIND_MATCH, stored_keys[i], '0, 1'b0));
              emitted++;
            end else if (others < OthersMax) begin
              others++;
            end
          end
        end
        queue_resp(make_resp(KIND_SUMMARY, '0, others, 1'b1));
      end
      default: begin
        // unused request code produces nothing
      end
    endcase
  endtask

  // compare one accepted response with the oldest prediction
  task automatic check_response(input resp_t got);
    resp_t want;
    results_seen++;
    if (awaited_resp.size() == 0) begin
      report_mismatch($sformatf("unexpected response kind %0d", got.kind));
      return;
    end
    want = awaited_resp.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
    if (got.match_key !== want.match_key)
      report_mismatch($sformatf("match_key %h, wanted %h", got.match_key, want.match_key));
    if (got.others_count !== want.others_count)
      report_mismatch($sformatf("others_count %0d, wanted %0d",
                                got.others_count, want.others_count));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0b, wanted %0b", got.last, want.last));
  endtask

  initial begin
    fails = 0;
    pending = 0;
    results_seen = 0;
    list_limit = 6'd10;
  end

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      stored_keys.delete();
      awaited_resp.delete();
      list_limit = 6'd10;
    end else begin
      if (cfg_we) list_limit = cfg_wdata;
      if (req_valid && req_ready) predict_request(req);
      if (resp_valid && resp_ready) check_response(resp);
    end
    pending = awaited_resp.size();
  end
endmodule

@@ dv/tb.sv @@
// testbench top for the sorted prefix match table: stimulus, handshake idling and verdict
module tb;
  import spm_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        resp_valid;
  logic        resp_ready;
  resp_t       resp;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;
  int          fails;
  int          pending;
  int          results_seen;

  int          send_idle;
  int          recv_idle;
  int          hold_left;
  int          sent_count;
  int          list_count;
  logic [63:0] added_keys[$];

  sorted_prefix_match_table dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .resp_valid(resp_valid), .resp_ready(resp_ready), .resp(resp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  spm_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .resp_valid(resp_valid), .resp_ready(resp_ready), .resp(resp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending), .results_seen(results_seen)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      resp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      resp_ready <= 1'b0;
    end else begin
      resp_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  initial begin
    #(8 * 1500000);
    $display("tb: done, errors");
    $finish;
  end

  // pack a short text big-endian into a key, zero padded
  function automatic logic [63:0] text_key(input string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[63 - 8 * i -: 8] = s[i];
    return k;
  endfunction

  // keys that share leading characters so prefixes find several matches
  function automatic logic [63:0] clustered_key();
    logic [63:0] k;
    byte         lead[3];
    int          n;
    lead[0] = "a";
    lead[1] = "r";
    lead[2] = "l";
    n = $urandom_range(1, 8);
    k = '0;
    k[63:56] = lead[$urandom_range(2)];
    if (n > 1) k[55:48] = 8'("a" + $urandom_range(2));
    for (int i = 2; i < n; i++) k[63 - 8 * i -: 8] = 8'("a" + $urandom_range(25));
    return k;
  endfunction

  function automatic logic [63:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send(input req_e t, input logic [63:0] k, input logic [3:0] plen);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req.req_type <= t;
    req.key <= k;
    req.prefix_len <= plen;
    do @(posedge clk); while (!req_ready);
    sent_count++;
    if (t == REQ_ADD) added_keys = {added_keys, k};
    if (t == REQ_LIST) list_count++;
  endtask

  // settle: all responses back, then a full chain pass for silent requests
  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TableDepth + 20) @(negedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic mixed_request();
    int          pick;
    logic [63:0] k;
    logic [3:0]  plen;
    pick = $urandom_range(99);
    k = ($urandom_range(99) < 75) ? clustered_key() : random_key();
    plen = ($urandom_range(99) < 70) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(15));
    if (pick < 35) begin
      send(REQ_ADD, k, 4'($urandom_range(15)));
    end else if (pick < 60) begin
      if (added_keys.size() > 0 && $urandom_range(99) < 70)
        k = added_keys[$urandom_range(added_keys.size() - 1)];
      send(REQ_REMOVE, k, 4'($urandom_range(15)));
    end else if (pick < 94) begin
      send(REQ_LIST, k, plen);
    end else begin
      send(REQ_NONE, k, plen);
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    resp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    sent_count = 0;
    list_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, duplicates, absent removes, prefix lengths, unused code
    send(REQ_LIST, '0, 4'd0);
    send(REQ_ADD, '0, 4'd0);
    send(REQ_ADD, {64{1'b1}}, 4'd15);
    send(REQ_ADD, text_key("apple"), 4'd1);
    send(REQ_ADD, text_key("apply"), 4'd8);
    send(REQ_ADD, text_key("ant"), 4'd2);
    send(REQ_ADD, text_key("rock"), 4'd3);
    send(REQ_ADD, text_key("lamp"), 4'd4);
    send(REQ_ADD, text_key("apple"), 4'd5);
    send(REQ_REMOVE, text_key("zebra"), 4'd6);
    send(REQ_LIST, text_key("ap"), 4'd2);
    send(REQ_LIST, text_key("a"), 4'd1);
    send(REQ_LIST, text_key("apple"), 4'd8);
    send(REQ_LIST, text_key("apple"), 4'd15);
    send(REQ_LIST, text_key("q"), 4'd9);
    send(REQ_LIST, '0, 4'd0);
    send(REQ_NONE, {64{1'b1}}, 4'd15);
    send(REQ_REMOVE, text_key("ant"), 4'd7);
    send(REQ_REMOVE, '0, 4'd0);
    send(REQ_REMOVE, {64{1'b1}}, 4'd10);
    send(REQ_LIST, text_key("a"), 4'd1);
    send(REQ_LIST, {64{1'b1}}, 4'd8);

    // limit zero: every match only counted
    wait_idle();
    write_limit(6'd0);
    repeat (4) send(REQ_LIST, clustered_key(), 4'($urandom_range(0, 2)));

    // limit one, sender light idling, receiver heavy
    wait_idle();
    write_limit(6'd1);
    send_idle = 19;
    recv_idle = 85;
    repeat (30) mixed_request();

    // limit at top, fill the table past full
    wait_idle();
    write_limit(6'd63);
    send_idle = 85;
    recv_idle = 19;
    repeat (262) send(REQ_ADD, ($urandom_range(99) < 50) ? clustered_key() : random_key(),
                      4'($urandom_range(15)));
    send(REQ_ADD, text_key("apple"), 4'd1);
    send(REQ_LIST, '0, 4'd0);
    send(REQ_LIST, text_key("a"), 4'd1);
    repeat (6) send(REQ_LIST, clustered_key(), 4'($urandom_range(1, 2)));

    // no idling, long receiver hold-off so the block backs up
    wait_idle();
    write_limit(6'($urandom_range(2, 62)));
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_left = 600;
    repeat (40) mixed_request();

    wait_idle();
    $display("tb: %0d requests sent (%0d lists), %0d responses checked",
             sent_count, list_count, results_seen);
    $display("tb: limits 0, 1, 10, 63 and one random; table driven past full");
    if (fails == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
